FILE: rtl/core/odo_pkg.sv
// Shared types, constants and helpers for the dead-reckoning odometry block.
package odo_pkg;

  localparam int AW   = 34;
  localparam int BW   = 32;
  localparam int PW   = AW + BW;
  localparam int CntW = 6;
  localparam int ZW   = 15;

  localparam logic [7:0] REG_TURN_GAIN      = 8'd0;
  localparam logic [7:0] REG_BACKWARD_GAIN  = 8'd1;
  localparam logic [7:0] REG_SIDE_GAIN      = 8'd2;
  localparam logic [7:0] REG_POSITION_SCALE = 8'd3;

  localparam logic [15:0] TURN_GAIN_RST      = 16'd437;
  localparam logic [15:0] BACKWARD_GAIN_RST  = 16'd45875;
  localparam logic [15:0] SIDE_GAIN_RST      = 16'd26214;
  localparam logic [23:0] POSITION_SCALE_RST = 24'd16777;

  localparam logic [31:0] SIN_C1 = 32'd1686629713;
  localparam logic [31:0] SIN_C3 = 32'd693598668;
  localparam logic [31:0] SIN_C5 = 32'd85569278;
  localparam logic [31:0] SIN_C7 = 32'd5026991;
  localparam logic [31:0] SIN_C9 = 32'd172273;

  localparam logic [15:0] QUARTER_TURN = 16'd16384;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_TURN,
    OP_FWD,
    OP_SIDE,
    OP_SQ,
    OP_P,
    OP_R,
    OP_VX1,
    OP_VX2,
    OP_VY1,
    OP_VY2,
    OP_DX,
    OP_DY
  } op_e;

  typedef struct packed {
    logic                 start;
    logic signed [AW-1:0] a;
    logic [BW-1:0]        b;
    logic [CntW-1:0]      n;
    logic                 b_signed;
  } mul_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [PW-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic [15:0] turn_gain;
    logic [15:0] backward_gain;
    logic [15:0] side_gain;
    logic [23:0] position_scale;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] forward_speed;
    logic signed [15:0] side_speed;
    logic signed [15:0] turn_speed;
    logic signed [15:0] body_height;
  } item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] height_out;
    logic [15:0]        heading_out;
  } res_t;

  function automatic logic [31:0] sin_coef(input logic [1:0] idx);
    logic [31:0] c;
    unique case (idx)
      2'd0:    c = SIN_C7;
      2'd1:    c = SIN_C5;
      2'd2:    c = SIN_C3;
      default: c = SIN_C1;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/odo_if.sv
// Handshake channel interfaces for odometry ticks, results and register writes.
interface odo_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] forward_speed;
  logic signed [15:0] side_speed;
  logic signed [15:0] turn_speed;
  logic signed [15:0] body_height;
  modport source (output valid, forward_speed, side_speed, turn_speed, body_height,
                  input ready);
  modport sink (input valid, forward_speed, side_speed, turn_speed, body_height,
                output ready);
endinterface

interface odo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] height_out;
  logic [15:0]        heading_out;
  modport source (output valid, pos_x, pos_y, height_out, heading_out, input ready);
  modport sink (input valid, pos_x, pos_y, height_out, heading_out, output ready);
endinterface

interface odo_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/odo_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
module odo_mul (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  odo_pkg::mul_req_t req_i,
  output odo_pkg::mul_rsp_t rsp_o
);
  import odo_pkg::*;

  logic                 busy_q, done_q, neg_q;
  logic [CntW-1:0]      cnt_q;
  logic signed [AW-1:0] a_q;
  logic [BW-1:0]        b_q;
  logic signed [PW-1:0] acc_q, acc_d, a_ext, addend;

  always_comb begin
    a_ext  = $signed({{(PW-AW){a_q[AW-1]}}, a_q});
    addend = '0;
    if (b_q[BW-1]) begin
      addend = neg_q ? -a_ext : a_ext;
    end
    acc_d = (acc_q <<< 1) + addend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.n;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      neg_q <= req_i.b_signed;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= b_q << 1;
      neg_q <= 1'b0;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

FILE: rtl/core/odo_datapath.sv
// Operation sequencer and state registers that drive the shared serial multiplier.
module odo_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  odo_pkg::item_t item_i,
  input  odo_pkg::cfg_t  cfg_i,
  output logic          res_valid_o,
  input  logic          res_take_i,
  output odo_pkg::res_t  res_o
);
  import odo_pkg::*;

  localparam logic signed [PW-1:0] Half14 = PW'(64'sd16384);
  localparam logic signed [PW-1:0] Half16 = PW'(64'sd32768);
  localparam logic signed [PW-1:0] Half38 = PW'(64'sd137438953472);

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   phase_q, phase_d;
  logic [1:0] pcnt_q, pcnt_d;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  logic signed [15:0] fwd_q, side_q, turn_q, height_q;
  logic signed [15:0] f_q, s_q, sn_q, cs_q;
  logic [15:0]        heading_q;
  logic signed [31:0] wx_q, wy_q;
  logic [31:0]        p_q;
  logic [30:0]        sq_q;
  logic [ZW-1:0]      z_q;
  logic               neg_q;
  logic signed [32:0] t_q, vx_q, vy_q;

  logic [15:0]        angle;
  logic [ZW-1:0]      z_w;
  logic signed [PW-1:0] r14, r16, r38, rq;
  logic [14:0]        mag;
  logic signed [15:0] sv;
  logic               accept, skip_fwd;

  odo_mul u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mreq),
    .rsp_o (mrsp)
  );

  always_comb begin
    angle = phase_q ? heading_q + QUARTER_TURN : heading_q;
    z_w   = angle[14] ? ZW'(17'd16384 - {3'b0, angle[13:0]}) : {1'b0, angle[13:0]};
    r14   = (mrsp.prod + Half14) >>> 15;
    r16   = (mrsp.prod + Half16) >>> 16;
    r38   = (mrsp.prod + Half38) >>> 38;
    rq    = ((mrsp.prod >>> 14) + Half14) >>> 15;
    mag   = (rq > PW'(64'sd32767)) ? 15'h7fff : rq[14:0];
    sv    = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    accept   = in_valid_i && (state_q == ST_IDLE);
    skip_fwd = (op_q == OP_FWD) && (fwd_q > 16'sd0);
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    phase_d = phase_q;
    pcnt_d  = pcnt_q;
    mreq    = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_ISSUE;
          op_d    = OP_TURN;
          phase_d = 1'b0;
        end
      end
      ST_ISSUE: begin
        if (skip_fwd) begin
          op_d = OP_SIDE;
        end else begin
          mreq.start = 1'b1;
          state_d    = ST_WAIT;
        end
        unique case (op_q)
          OP_TURN: begin
            mreq.a = AW'(turn_q); mreq.b = {cfg_i.turn_gain, 16'b0}; mreq.n = CntW'(16);
          end
          OP_FWD: begin
            mreq.a = AW'(fwd_q); mreq.b = {cfg_i.backward_gain, 16'b0}; mreq.n = CntW'(16);
          end
          OP_SIDE: begin
            mreq.a = AW'(side_q); mreq.b = {cfg_i.side_gain, 16'b0}; mreq.n = CntW'(16);
          end
          OP_SQ: begin
            mreq.a = $signed({{(AW-ZW){1'b0}}, z_w}); mreq.b = {z_w, 17'b0};
            mreq.n = CntW'(ZW);
          end
          OP_P: begin
            mreq.a = $signed({2'b0, p_q}); mreq.b = {sq_q, 1'b0}; mreq.n = CntW'(31);
          end
          OP_R: begin
            mreq.a = $signed({2'b0, p_q}); mreq.b = {z_q, 17'b0}; mreq.n = CntW'(ZW);
          end
          OP_VX1, OP_VY2: begin
            mreq.a = AW'(cs_q); mreq.b = {(op_q == OP_VX1) ? f_q : s_q, 16'b0};
            mreq.n = CntW'(16); mreq.b_signed = 1'b1;
          end
          OP_VX2, OP_VY1: begin
            mreq.a = AW'(sn_q); mreq.b = {(op_q == OP_VX2) ? s_q : f_q, 16'b0};
            mreq.n = CntW'(16); mreq.b_signed = 1'b1;
          end
          OP_DX, OP_DY: begin
            mreq.a = AW'((op_q == OP_DX) ? vx_q : vy_q);
            mreq.b = {cfg_i.position_scale, 8'b0}; mreq.n = CntW'(24);
          end
          default: mreq = '0;
        endcase
        if (skip_fwd) begin
          mreq.start = 1'b0;
        end
      end
      ST_WAIT: begin
        if (mrsp.done) begin
          state_d = ST_ISSUE;
          unique case (op_q)
            OP_TURN: op_d = OP_FWD;
            OP_FWD:  op_d = OP_SIDE;
            OP_SIDE: op_d = OP_SQ;
            OP_SQ: begin
              op_d   = OP_P;
              pcnt_d = 2'd0;
            end
            OP_P: begin
              pcnt_d = pcnt_q + 2'd1;
              if (pcnt_q == 2'd3) begin
                op_d = OP_R;
              end
            end
            OP_R: begin
              op_d    = phase_q ? OP_VX1 : OP_SQ;
              phase_d = 1'b1;
            end
            OP_VX1: op_d = OP_VX2;
            OP_VX2: op_d = OP_VY1;
            OP_VY1: op_d = OP_VY2;
            OP_VY2: op_d = OP_DX;
            OP_DX:  op_d = OP_DY;
            OP_DY:  state_d = ST_DONE;
            default: op_d = OP_TURN;
          endcase
        end
      end
      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_TURN;
      phase_q <= 1'b0;
      pcnt_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      phase_q <= phase_d;
      pcnt_q  <= pcnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_q <= '0;
      wx_q      <= '0;
      wy_q      <= '0;
    end else if (state_q == ST_WAIT && mrsp.done) begin
      if (op_q == OP_TURN) begin
        heading_q <= heading_q + r14[15:0];
      end
      if (op_q == OP_DX) begin
        wx_q <= wx_q + r38[31:0];
      end
      if (op_q == OP_DY) begin
        wy_q <= wy_q + r38[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_q    <= item_i.forward_speed;
      side_q   <= item_i.side_speed;
      turn_q   <= item_i.turn_speed;
      height_q <= item_i.body_height;
    end
    if (state_q == ST_ISSUE) begin
      if (skip_fwd) begin
        f_q <= fwd_q;
      end
      if (op_q == OP_SQ) begin
        z_q   <= z_w;
        neg_q <= angle[15];
        p_q   <= SIN_C9;
      end
    end
    if (state_q == ST_WAIT && mrsp.done) begin
      unique case (op_q)
        OP_FWD:  f_q  <= r16[15:0];
        OP_SIDE: s_q  <= r16[15:0];
        OP_SQ:   sq_q <= {mrsp.prod[28:0], 2'b0};
        OP_P:    p_q  <= sin_coef(pcnt_q) - mrsp.prod[61:30];
        OP_R: begin
          if (phase_q) begin
            cs_q <= sv;
          end else begin
            sn_q <= sv;
          end
        end
        OP_VX1, OP_VY1: t_q <= mrsp.prod[32:0];
        OP_VX2:  vx_q <= t_q - mrsp.prod[32:0];
        OP_VY2:  vy_q <= t_q + mrsp.prod[32:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o        = (state_q == ST_IDLE);
  assign res_valid_o       = (state_q == ST_DONE);
  assign res_o.pos_x       = wx_q;
  assign res_o.pos_y       = wy_q;
  assign res_o.height_out  = height_q;
  assign res_o.heading_out = heading_q;

`ifndef NO_ASSERTIONS
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mrsp.done |-> state_q == ST_WAIT)
    else $error("multiplier finished outside wait state");
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_ISSUE && op_q == OP_TURN && !phase_q)
    else $error("accepted tick did not start with heading update");
  a_take_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && res_take_i) |=> state_q == ST_IDLE)
    else $error("result transfer did not return to idle");
  a_start_in_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mreq.start |-> state_q == ST_ISSUE)
    else $error("multiplier started outside issue state");
`endif

endmodule

FILE: rtl/core/dead_reckoning_odometry.sv
// Top level: register file, output register and sequencer of the odometry block.
//
//   channel  dir  payload
//   in_i     in   forward_speed, side_speed, turn_speed, body_height
//   out_o    out  pos_x, pos_y, height_out, heading_out
//   cfg_i    in   index (0..3), data
//
// Each tick runs twenty or twenty-one passes of the shared bit-serial multiplier (one bit
// a cycle); the forward pass drops when forward speed is positive. A new input is taken
// only once the sequencer has handed its last result to the output register.
// Reset clears heading, positions and loads default gains; no clearing pass.
// A finished result waits in the output register while the next tick runs.
module dead_reckoning_odometry (
  input logic  clk_i,
  input logic  rst_ni,
  odo_in_if.sink    in_i,
  odo_out_if.source out_o,
  odo_cfg_if.sink   cfg_i
);
  import odo_pkg::*;

  cfg_t  cfg_q;
  item_t item;
  res_t  res, out_q;
  logic  res_valid, res_take, out_valid_q;

  assign item.forward_speed = in_i.forward_speed;
  assign item.side_speed    = in_i.side_speed;
  assign item.turn_speed    = in_i.turn_speed;
  assign item.body_height   = in_i.body_height;

  odo_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .item_i     (item),
    .cfg_i      (cfg_q),
    .res_valid_o(res_valid),
    .res_take_i (res_take),
    .res_o      (res)
  );

  assign res_take    = res_valid && (!out_valid_q || out_o.ready);
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.turn_gain      <= TURN_GAIN_RST;
      cfg_q.backward_gain  <= BACKWARD_GAIN_RST;
      cfg_q.side_gain      <= SIDE_GAIN_RST;
      cfg_q.position_scale <= POSITION_SCALE_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_TURN_GAIN:      cfg_q.turn_gain      <= cfg_i.data[15:0];
        REG_BACKWARD_GAIN:  cfg_q.backward_gain  <= cfg_i.data[15:0];
        REG_SIDE_GAIN:      cfg_q.side_gain      <= cfg_i.data[15:0];
        REG_POSITION_SCALE: cfg_q.position_scale <= cfg_i.data[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pos_x       = out_q.pos_x;
  assign out_o.pos_y       = out_q.pos_y;
  assign out_o.height_out  = out_q.height_out;
  assign out_o.heading_out = out_q.heading_out;

`ifndef NO_ASSERTIONS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> out_valid_q && $stable(out_q))
    else $error("stalled result changed");
  a_take_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take |-> (!out_valid_q || out_o.ready))
    else $error("result overwrote pending output");
  a_busy_no_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !in_i.ready)
    else $error("input ready while result pending in sequencer");
`endif

endmodule
